/* rtl/dwc_pkg.sv */
`default_nettype none
package dwc_pkg;
	localparam int MaxWords = 256;
	localparam int WordChars = 32;
	localparam int CntW = $clog2(MaxWords + 1);
	localparam int LenW = $clog2(WordChars + 2);
	localparam int PosW = $clog2(WordChars);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} dwc_in_t;

	typedef struct packed {
		logic       word_is_new;
		logic [8:0] distinct_count;
		logic       table_full;
		logic       word_truncated;
		logic       last;
	} dwc_out_t;

	typedef struct packed {
		logic           char_en;
		logic           word_start;
		logic [PosW-1:0] pos;
		logic [7:0]     ch;
		logic [LenW-1:0] len;
		logic           clear;
	} dwc_cell_ctl_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'd65 && c <= 8'd90) begin
			fold_case = c + 8'd32;
		end else begin
			fold_case = c;
		end
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd11) ||
			(c == 8'd12) || (c == 8'd13);
	endfunction
endpackage
`default_nettype wire

/* rtl/distinct_word_counter_unit.sv */
`default_nettype none
// Distinct word counter.
// Input: one byte beat is accepted on each rising edge with start high and busy
// low; busy is always low, so a byte can be taken every cycle. Each beat carries
// text_byte and end_of_text.
// Output: a result beat is shown for one cycle with strobe high, in the cycle
// after the byte that ends a word (whitespace) or ends the text. The receiver
// cannot hold results off; results are never dropped.
// Each table entry is a cell in a row; a word character is broadcast to all
// cells, which track their own match flag, and the word end is checked in the
// same cycle. A new word is written into the first free cell, the one whose index
// equals the count, with the store enable passed down a chain of cells.
// Throughput: one byte per cycle.
// Reset: table emptied, count zero, no word pending. End of text also empties
// the table after its result.
module distinct_word_counter_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  dwc_pkg::dwc_in_t  in_beat,
	output logic              strobe,
	output dwc_pkg::dwc_out_t out_beat
);
	import dwc_pkg::*;
	logic [7:0]      word_q [WordChars];
	logic [LenW-1:0] len_q;
	logic            in_word_q;
	logic [CntW-1:0] count_q;
	logic            acc, ws, eot, wend, found, store;
	logic [LenW-1:0] new_len, eff_len;
	logic [7:0]      word_n [WordChars];
	logic [MaxWords-1:0] hits;
	logic [MaxWords-1:0] free_chain;
	dwc_cell_ctl_t   ctl;

	assign busy = 1'b0;
	assign acc  = start;
	assign ws   = is_space(in_beat.text_byte);
	assign eot  = in_beat.end_of_text;

	always_comb begin
		word_n  = word_q;
		new_len = in_word_q ? len_q : '0;
		if (acc && !ws) begin
			if (new_len < LenW'(WordChars)) begin
				word_n[new_len[PosW-1:0]] = in_beat.text_byte;
				new_len = new_len + 1'b1;
			end else begin
				new_len = LenW'(WordChars + 1);
			end
		end
	end

	assign wend    = acc && (ws || eot) && (in_word_q || !ws);
	assign eff_len = (new_len > LenW'(WordChars)) ? LenW'(WordChars) : new_len;

	always_comb begin
		ctl.word_start = acc && !ws && !in_word_q;
		ctl.char_en    = acc && !ws && (new_len <= LenW'(WordChars)) &&
			!(in_word_q && len_q >= LenW'(WordChars));
		ctl.pos        = in_word_q ? len_q[PosW-1:0] : '0;
		ctl.ch         = in_beat.text_byte;
		ctl.len        = eff_len;
		ctl.clear      = acc && eot;
	end

	assign found = |hits;
	assign store = wend && !found && (count_q < CntW'(MaxWords));
	assign free_chain[0] = store;

	genvar g;
	generate
		for (g = 0; g < MaxWords; g++) begin : g_cell
			dwc_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .load(store),
				.load_chars(word_n), .prev_match(free_chain[g] && (count_q == CntW'(g))),
				.hit(hits[g])
			);
			if (g < MaxWords - 1) begin : g_link
				assign free_chain[g+1] = free_chain[g];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			in_word_q <= 1'b0;
			count_q   <= '0;
			strobe    <= 1'b0;
		end else begin
			strobe <= acc && (wend || eot);
			if (acc) begin
				if (eot) begin
					count_q   <= '0;
					in_word_q <= 1'b0;
					len_q     <= '0;
				end else begin
					in_word_q <= !ws;
					len_q     <= ws ? '0 : new_len;
					if (store) begin
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			word_q <= word_n;
			out_beat.word_is_new    <= wend && !found;
			out_beat.distinct_count <= 9'(count_q + CntW'(store));
			out_beat.table_full     <= wend && !found && !store;
			out_beat.word_truncated <= wend && (new_len > LenW'(WordChars));
			out_beat.last           <= eot;
		end
	end
endmodule
`default_nettype wire

/* rtl/dwc_cell.sv */
`default_nettype none
module dwc_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dwc_pkg::dwc_cell_ctl_t ctl,
	input  wire                   load,
	input  wire [7:0]             load_chars [dwc_pkg::WordChars],
	input  wire                   prev_match,
	output logic                  hit
);
	import dwc_pkg::*;
	logic [7:0]      chars_q [WordChars];
	logic [LenW-1:0] len_q;
	logic            valid_q;
	logic            match_q;
	logic            cur;
	logic            cmp;
	logic            nxt;

	assign cur = ctl.word_start ? 1'b1 : match_q;
	assign cmp = ({1'b0, ctl.pos} < len_q) && (fold_case(chars_q[ctl.pos]) == fold_case(ctl.ch));
	assign nxt = ctl.char_en ? (cur & cmp) : cur;
	assign hit = valid_q && nxt && (len_q == ctl.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b1;
		end else begin
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (load && prev_match) begin
				valid_q <= 1'b1;
			end
			if (ctl.char_en) begin
				match_q <= nxt;
			end else if (ctl.word_start) begin
				match_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && prev_match && !valid_q) begin
			chars_q <= load_chars;
			len_q   <= ctl.len;
		end
	end
endmodule
`default_nettype wire
